>>> rtl/first_fit_heap_allocator_core_macros.svh
// Assertion helpers for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
package ffha_pkg;

    // Width of the divider dividend and quotient
    localparam int QW = 16;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OOM    = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_NULL   = 3'd3;
    localparam logic [2:0] ST_DOUBLE = 3'd4;
    localparam logic [2:0] ST_BAD    = 3'd5;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic          done;
        logic          rem_zero;
        logic [QW-1:0] quot;
    } div_res_t;

    // Sequencer states
    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_DIV    = 14'b00000000000100,
        S_AWALK  = 14'b00000000001000,
        S_AEVAL  = 14'b00000000010000,
        S_ASPLIT = 14'b00000000100000,
        S_GROW   = 14'b00000001000000,
        S_FCHK   = 14'b00000010000000,
        S_CWALK  = 14'b00000100000000,
        S_CEVAL  = 14'b00001000000000,
        S_CQ     = 14'b00010000000000,
        S_CQEVAL = 14'b00100000000000,
        S_CPW    = 14'b01000000000000,
        S_RESULT = 14'b10000000000000
    } state_t;

endpackage

>>> rtl/first_fit_heap_allocator_core.sv
// Steps: accept, divider shift, a read and an evaluate state per chunk header walked, result.
// Allocate walks up to the first fit, plus a step to split it or a step to grow the top.
// Free adds a header check, walks the whole chunk list, probes past each free run, and merges.
// Throughput: one item at a time; the header walk over the single-port-read header RAM
// sets the rate, so time grows with the number of chunks.
// Reset: counters, heap top and control clear at once; a clearing pass then sweeps the whole
// header RAM, and no item is accepted until it ends.
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int ARENA_UNITS  = 4096,
    parameter int UNIT_BYTES   = 8,
    parameter int HEADER_UNITS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data,     // arena_limit_units
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,      // size_bytes[14:0], addr[29:15], zero pad
    input  logic [0:0]   s_tuser,      // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata       // status[2:0], addr_out[17:3], total_requested[49:18],
                                       // grow_count[81:50], corrupt_count[97:82], zero pad
);

    localparam int AW = $clog2(ARENA_UNITS);
    localparam int PW = AW + 1;
    localparam int EW = AW + 2;
    localparam int SW = ((PW > QW) ? PW : QW) + 2;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] q_reg, q_next;
    logic [PW-1:0] top_reg, top_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] psize_reg, psize_next;
    logic [QW-1:0] units_reg, units_next;
    logic          op_reg, op_next;
    logic [14:0]   bytes_reg, bytes_next;
    logic [14:0]   addr_reg, addr_next;
    logic [12:0]   limit_reg, limit_next;
    logic [31:0]   sum_reg, sum_next;
    logic [31:0]   grow_reg, grow_next;
    logic [15:0]   bad_reg, bad_next;
    logic [2:0]    status_reg, status_next;
    logic [14:0]   aout_reg, aout_next;
    logic          mv_reg, mv_next;
    logic [103:0]  md_reg, md_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic          e_valid, e_free;
    logic [AW-1:0] e_size;
    logic          div_start;
    logic [QW-1:0] div_dvd;
    div_res_t      div_res;
    logic [SW-1:0] hx, lim, grow_end, split_n;
    logic [32:0]   sum_add;
    logic          bad_addr;

    // Next chunk header after a chunk at ptr with payload sz
    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] ptr, input logic [AW-1:0] sz);
        return PW'(SW'(ptr) + SW'(HEADER_UNITS) + SW'(sz));
    endfunction

    // Payload byte offset of the chunk at ptr
    function automatic logic [14:0] payload_of(input logic [PW-1:0] ptr);
        return 15'((SW'(ptr) + SW'(HEADER_UNITS)) * SW'(UNIT_BYTES));
    endfunction

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (ARENA_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ffha_div #(
        .UNIT_BYTES (UNIT_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .res      (div_res)
    );

    assign e_valid = rdata[AW+1];
    assign e_free  = rdata[AW];
    assign e_size  = rdata[AW-1:0];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;

    // Round up for allocate, plain offset for free
    assign div_dvd = (s_tuser[0] == OP_FREE) ? QW'(s_tdata[29:15])
                                             : QW'(s_tdata[14:0]) + QW'(UNIT_BYTES - 1);

    assign hx       = SW'(div_res.quot) - SW'(HEADER_UNITS);
    assign bad_addr = !div_res.rem_zero || (div_res.quot < QW'(HEADER_UNITS))
                      || (hx >= SW'(top_reg)) || (hx >= SW'(ARENA_UNITS));
    assign lim      = (SW'(limit_reg) > SW'(ARENA_UNITS)) ? SW'(ARENA_UNITS) : SW'(limit_reg);
    assign grow_end = SW'(top_reg) + SW'(HEADER_UNITS) + SW'(units_reg);
    assign split_n  = SW'(p_reg) + SW'(HEADER_UNITS) + SW'(units_reg);
    assign sum_add  = {1'b0, sum_reg} + 33'(bytes_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        top_next    = top_reg;
        h_next      = h_reg;
        psize_next  = psize_reg;
        units_next  = units_reg;
        op_next     = op_reg;
        bytes_next  = bytes_reg;
        addr_next   = addr_reg;
        limit_next  = limit_reg;
        sum_next    = sum_reg;
        grow_next   = grow_reg;
        bad_next    = bad_reg;
        status_next = status_reg;
        aout_next   = aout_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        we          = 1'b0;
        waddr       = p_reg[AW-1:0];
        wdata       = '0;
        raddr       = p_reg[AW-1:0];
        div_start   = 1'b0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the header RAM to all-invalid
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == AW'(ARENA_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser[0];
                    bytes_next = s_tdata[14:0];
                    addr_next  = s_tdata[29:15];
                    aout_next  = '0;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                raddr = hx[AW-1:0];
                if (div_res.done)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        sum_next   = sum_add[32] ? '1 : sum_add[31:0];
                        units_next = div_res.quot;
                        p_next     = '0;
                        if (bytes_reg == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_AWALK;
                        end
                    end
                    else if (addr_reg == '0)
                    begin
                        status_next = ST_NULL;
                        state_next  = S_RESULT;
                    end
                    else if (bad_addr)
                    begin
                        if (bad_reg != '1)
                        begin
                            bad_next = bad_reg + 16'd1;
                        end
                        status_next = ST_BAD;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        h_next     = hx[AW-1:0];
                        state_next = S_FCHK;
                    end
                end
            end
            S_AWALK:
            begin
                state_next = (p_reg < top_reg) ? S_AEVAL : S_GROW;
            end
            S_AEVAL:
            begin
                if (!e_valid)
                begin
                    state_next = S_GROW;
                end
                else if (e_free && (SW'(e_size) >= SW'(units_reg)))
                begin
                    if ((SW'(e_size) - SW'(units_reg) >= SW'(HEADER_UNITS + 1))
                        && (split_n < SW'(ARENA_UNITS)))
                    begin
                        // Carve off the tail as a new free chunk
                        we         = 1'b1;
                        waddr      = split_n[AW-1:0];
                        wdata      = {1'b1, 1'b1,
                                      AW'(SW'(e_size) - SW'(units_reg) - SW'(HEADER_UNITS))};
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = {1'b1, 1'b0, e_size};
                        status_next = ST_OK;
                        aout_next   = payload_of(p_reg);
                        state_next  = S_RESULT;
                    end
                end
                else
                begin
                    p_next     = nxt(p_reg, e_size);
                    state_next = S_AWALK;
                end
            end
            S_ASPLIT:
            begin
                we          = 1'b1;
                wdata       = {1'b1, 1'b0, units_reg[AW-1:0]};
                status_next = ST_OK;
                aout_next   = payload_of(p_reg);
                state_next  = S_RESULT;
            end
            S_GROW:
            begin
                if (grow_reg != '1)
                begin
                    grow_next = grow_reg + 32'd1;
                end
                if ((SW'(top_reg) >= SW'(ARENA_UNITS)) || (grow_end > lim))
                begin
                    status_next = ST_OOM;
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = top_reg[AW-1:0];
                    wdata       = {1'b1, 1'b0, units_reg[AW-1:0]};
                    top_next    = PW'(grow_end);
                    status_next = ST_OK;
                    aout_next   = payload_of(top_reg);
                end
                state_next = S_RESULT;
            end
            S_FCHK:
            begin
                if (!e_valid)
                begin
                    if (bad_reg != '1)
                    begin
                        bad_next = bad_reg + 16'd1;
                    end
                    status_next = ST_BAD;
                    state_next  = S_RESULT;
                end
                else if (e_free)
                begin
                    status_next = ST_DOUBLE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = h_reg;
                    wdata      = {1'b1, 1'b1, e_size};
                    p_next     = '0;
                    state_next = S_CWALK;
                end
            end
            S_CWALK:
            begin
                if (p_reg < top_reg)
                begin
                    state_next = S_CEVAL;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
            end
            S_CEVAL:
            begin
                if (!e_valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else if (e_free)
                begin
                    psize_next = e_size;
                    q_next     = nxt(p_reg, e_size);
                    state_next = S_CQ;
                end
                else
                begin
                    p_next     = nxt(p_reg, e_size);
                    state_next = S_CWALK;
                end
            end
            S_CQ:
            begin
                raddr = q_reg[AW-1:0];
                if (q_reg < top_reg)
                begin
                    state_next = S_CQEVAL;
                end
                else
                begin
                    p_next     = nxt(p_reg, psize_reg);
                    state_next = S_CWALK;
                end
            end
            S_CQEVAL:
            begin
                if (e_valid && e_free)
                begin
                    // Absorb the neighbor and drop its header
                    psize_next = AW'(SW'(psize_reg) + SW'(HEADER_UNITS) + SW'(e_size));
                    q_next     = nxt(p_reg, psize_next);
                    we         = 1'b1;
                    waddr      = q_reg[AW-1:0];
                    wdata      = '0;
                    state_next = S_CPW;
                end
                else
                begin
                    p_next     = q_reg;
                    state_next = S_CWALK;
                end
            end
            S_CPW:
            begin
                we         = 1'b1;
                wdata      = {1'b1, 1'b1, psize_reg};
                state_next = S_CQ;
            end
            S_RESULT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {6'd0, bad_reg, grow_reg, sum_reg, aout_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            top_reg   <= '0;
            limit_reg <= 13'd4096;
            sum_reg   <= '0;
            grow_reg  <= '0;
            bad_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            limit_reg <= limit_next;
            sum_reg   <= sum_next;
            grow_reg  <= grow_next;
            bad_reg   <= bad_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        h_reg      <= h_next;
        psize_reg  <= psize_next;
        units_reg  <= units_next;
        op_reg     <= op_next;
        bytes_reg  <= bytes_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        aout_reg   <= aout_next;
        md_reg     <= md_next;
    end

    `FFHA_ASSERT_IMP(a_top_in_arena, 1'b1, top_reg <= PW'(ARENA_UNITS), "heap top beyond arena")
    `FFHA_ASSERT_NXT(a_accept_starts_div, s_tvalid && s_tready, state_reg == S_DIV, "item not sent to divider")
    `FFHA_ASSERT_IMP(a_result_from_seq, $rose(m_tvalid), $past(state_reg == S_RESULT), "result without sequencer")
    `FFHA_ASSERT_NXT(a_grow_monotonic, 1'b1, grow_reg >= $past(grow_reg), "grow count decreased")

endmodule

>>> rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ffha_div.sv
module ffha_div
    import ffha_pkg::*;
#(
    parameter int UNIT_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    output div_res_t      res
);

    // UNIT_BYTES must be a power of two (the block does not enforce it): the quotient is a shift, the remainder a mask
    localparam int RW = $clog2(UNIT_BYTES);

    logic          done_reg, done_next;
    logic [QW-1:0] dvd_reg, dvd_next;

    // Capture the dividend on start; the result is registered and ready in the next cycle
    always_comb
    begin
        done_next = start;
        dvd_next  = start ? dividend : dvd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
    end

    assign res = {done_reg, (dvd_reg[RW-1:0] == '0), QW'(dvd_reg >> RW)};

endmodule
